// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL of the Euler-to-quaternion block.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Clocked property, switched off while reset is asserted.
`define E2Q_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked property, checked at every edge including reset.
`define E2Q_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define E2Q_ASSERT(lbl, clk, rst_n, prop, msg)
`define E2Q_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== src/e2q_pkg.sv =====
// Package for the Euler-to-quaternion block: constants, CORDIC cell type,
// arctangent table and the radix-256 divide-by-360 digit step. No dependencies.
package e2q_pkg;

  localparam int CORDIC_STAGES_DEF = 24;
  localparam int ANG_W = 34;
  localparam int ANG_LAT = 10;
  localparam int QUAT_LAT = 5;

  localparam logic [15:0] RECIP_360 = 16'd46604;  // ceil(2^24 / 360)
  localparam logic [31:0] PI_Q30_U = 32'd3373259426;
  localparam logic [24:0] HALF_D360 = 25'd11796480;
  localparam logic signed [ANG_W-1:0] PI_Q30 = 34'sd3373259426;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [ANG_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

  typedef struct packed {
    logic signed [ANG_W-1:0] x;
    logic signed [ANG_W-1:0] y;
    logic signed [ANG_W-1:0] z;
    logic                    flip;
  } cordic_t;

  function automatic logic signed [ANG_W-1:0] atan_q30(input logic [4:0] k);
    logic [31:0] v;
    unique case (k)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      5'd24: v = 32'h0000003F;
      5'd25: v = 32'h0000001F;
      5'd26: v = 32'h0000000F;
      5'd27: v = 32'h00000008;
      5'd28: v = 32'h00000004;
      5'd29: v = 32'h00000002;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return $signed({2'b00, v});
  endfunction

  // One radix-256 digit of a division by 360: t = rem*256 + byte, rem < 360.
  // Returns {quotient digit, new remainder}.
  function automatic logic [16:0] div360_digit(input logic [16:0] t);
    logic [33:0] p;
    logic [8:0]  qe;
    logic [17:0] pr;
    logic [17:0] rm;
    p  = 34'(t) * 34'(RECIP_360);
    qe = p[32:24];
    pr = 18'(qe) * 18'd360;
    if (pr > 18'(t)) begin
      qe = qe - 9'd1;
      pr = pr - 18'd360;
    end
    rm = 18'(t) - pr;
    return {qe[7:0], rm[8:0]};
  endfunction

endpackage

// ===== src/euler_to_quaternion_top.sv =====
// Top level of the Euler-to-quaternion converter: angle front ends, three
// CORDIC cell chains and the quaternion back end. Uses e2q_pkg, assert_macros.svh.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------------
//   in_     | into      | in_valid/in_stall   | pitch, yaw, roll (Q16.16 degrees)
//   out_    | out of    | out_valid/out_stall | quat x, y, z, w (Q2.30)
//
// One transaction in per cycle, one quaternion out per cycle, steady state with out_stall low.
// The pipe runs through the angle front end (modulo, multiply by pi,
// six radix-256 divide-by-360 digits, quadrant fold), a registered stage in
// each CORDIC cell, and the product and rounding back end.
// rst_n (synchronous, active low) clears only the stage valid bits.
// The whole pipe advances together; it freezes only when a result sits in
// the output register and out_stall is high, and in_stall follows that.
`include "assert_macros.svh"

module euler_to_quaternion_top #(
  parameter int CORDIC_STAGES = e2q_pkg::CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_pitch_deg,
  input  logic signed [31:0] in_yaw_deg,
  input  logic signed [31:0] in_roll_deg,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_quat_x,
  output logic signed [31:0] out_quat_y,
  output logic signed [31:0] out_quat_z,
  output logic signed [31:0] out_quat_w
);
  import e2q_pkg::*;

  localparam int LAT = ANG_LAT + CORDIC_STAGES + QUAT_LAT;

  logic               adv;
  logic [LAT-1:0]     vld_r;
  logic [LAT-1:0]     vld_nxt;
  logic signed [31:0] raw [3];
  cordic_t            chain [3][CORDIC_STAGES+1];

  // pipe moves unless a finished result is held by the sink
  assign adv      = !vld_r[LAT-1] || !out_stall;
  assign in_stall = !adv;

  assign raw[0] = in_pitch_deg;
  assign raw[1] = in_yaw_deg;
  assign raw[2] = in_roll_deg;

  always_comb begin
    vld_nxt = {vld_r[LAT-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  genvar a, i;
  generate
    for (a = 0; a < 3; a++) begin : g_axis
      e2q_angle u_angle (
        .clk    (clk),
        .en     (adv),
        .raw_i  (raw[a]),
        .cell_o (chain[a][0])
      );
      for (i = 0; i < CORDIC_STAGES; i++) begin : g_cell
        e2q_cell #(.IDX(i)) u_cell (
          .clk (clk),
          .en  (adv),
          .d_i (chain[a][i]),
          .d_o (chain[a][i+1])
        );
      end
    end
  endgenerate

  e2q_quat u_quat (
    .clk      (clk),
    .en       (adv),
    .p_i      (chain[0][CORDIC_STAGES]),
    .y_i      (chain[1][CORDIC_STAGES]),
    .r_i      (chain[2][CORDIC_STAGES]),
    .quat_x_o (out_quat_x),
    .quat_y_o (out_quat_y),
    .quat_z_o (out_quat_z),
    .quat_w_o (out_quat_w)
  );

  assign out_valid = vld_r[LAT-1];

  // frozen pipe keeps every stage valid bit
  `E2Q_ASSERT(a_freeze, clk, rst_n, !adv |=> $stable(vld_r), "pipe moved while frozen")
  // an accepted transaction occupies the first stage
  `E2Q_ASSERT(a_take, clk, rst_n, (in_valid && !in_stall) |=> vld_r[0], "transaction lost")
  // after a result is taken, the next one comes from the stage before
  `E2Q_ASSERT(a_drain, clk, rst_n, (out_valid && !out_stall) |=> (out_valid == $past(vld_r[LAT-2])), "output stage out of step")

endmodule

// ===== src/e2q_angle.sv =====
// Angle front end: reduces a Q16.16 degree angle modulo 360, converts the
// half angle to Q2.30 radians and folds it into +-pi/2. Uses e2q_pkg.
module e2q_angle (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] raw_i,
  output e2q_pkg::cordic_t   cell_o
);
  import e2q_pkg::*;

  localparam int NDIG = 6;

  // stage 1: magnitude and quotient estimate of |raw| / (360 * 2^16)
  logic [31:0] mag_r1;
  logic        neg_r1;
  logic [31:0] prod_r1;
  // stage 2: remainder
  logic [24:0] rem_r2;
  logic        neg_r2;
  // stage 3: scaled numerator
  logic [56:0] num_r3;
  logic        neg_r3;
  // digit stages
  logic [47:0] vv_r [NDIG];
  logic [47:0] qq_r [NDIG];
  logic [8:0]  rm_r [NDIG];
  logic        ng_r [NDIG];
  cordic_t     cell_r;

  logic [31:0] mag_nxt;
  logic [6:0]  q360;
  logic [15:0] q360_m;
  logic [31:0] rfull;

  always_comb begin
    mag_nxt = raw_i[31] ? 32'(-raw_i) : 32'(raw_i);
    q360    = prod_r1[30:24];
    q360_m  = 16'(q360) * 16'd360;
    rfull   = mag_r1 - {q360_m, 16'h0000};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r1  <= mag_nxt;
      neg_r1  <= raw_i[31];
      prod_r1 <= 32'(mag_nxt[31:16]) * 32'(RECIP_360);
      rem_r2  <= rfull[24:0];
      neg_r2  <= neg_r1;
      num_r3  <= 57'(rem_r2) * 57'(PI_Q30_U) + 57'(HALF_D360);
      neg_r3  <= neg_r2;
    end
  end

  genvar j;
  generate
    for (j = 0; j < NDIG; j++) begin : g_dig
      logic [47:0] v_in;
      logic [47:0] q_in;
      logic [8:0]  r_in;
      logic        n_in;
      logic [16:0] dq;
      if (j == 0) begin : g_first
        assign v_in = {7'b0, num_r3[56:16]};
        assign q_in = '0;
        assign r_in = '0;
        assign n_in = neg_r3;
      end else begin : g_next
        assign v_in = vv_r[j-1];
        assign q_in = qq_r[j-1];
        assign r_in = rm_r[j-1];
        assign n_in = ng_r[j-1];
      end
      assign dq = div360_digit({r_in, v_in[8*(NDIG-1-j) +: 8]});
      always_ff @(posedge clk) begin
        if (en) begin
          vv_r[j] <= v_in;
          qq_r[j] <= q_in | (48'(dq[16:9]) << (8*(NDIG-1-j)));
          rm_r[j] <= dq[8:0];
          ng_r[j] <= n_in;
        end
      end
    end
  endgenerate

  logic signed [ANG_W-1:0] th_mag;
  logic signed [ANG_W-1:0] th;
  cordic_t                 cell_nxt;

  always_comb begin
    th_mag   = $signed({1'b0, qq_r[NDIG-1][32:0]});
    th       = ng_r[NDIG-1] ? -th_mag : th_mag;
    cell_nxt = '{x: CORDIC_GAIN_Q30, y: '0, z: th, flip: 1'b0};
    if (th > HALF_PI_Q30) begin
      cell_nxt.z    = th - PI_Q30;
      cell_nxt.flip = 1'b1;
    end else if (th < -HALF_PI_Q30) begin
      cell_nxt.z    = th + PI_Q30;
      cell_nxt.flip = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_o = cell_r;

endmodule

// ===== src/e2q_cell.sv =====
// One CORDIC rotation cell: a single micro-rotation, registered.
// Uses e2q_pkg for the cell type and the arctangent table.
module e2q_cell #(
  parameter int IDX = 0
) (
  input  logic             clk,
  input  logic             en,
  input  e2q_pkg::cordic_t d_i,
  output e2q_pkg::cordic_t d_o
);
  import e2q_pkg::*;

  localparam logic [4:0] SH = 5'(IDX % 32);

  cordic_t                 d_r;
  cordic_t                 d_nxt;
  logic signed [ANG_W-1:0] dx;
  logic signed [ANG_W-1:0] dy;
  logic signed [ANG_W-1:0] at;

  always_comb begin
    dx    = d_i.y >>> SH;
    dy    = d_i.x >>> SH;
    at    = atan_q30(SH);
    d_nxt = d_i;
    if (!d_i.z[ANG_W-1]) begin
      d_nxt.x = d_i.x - dx;
      d_nxt.y = d_i.y + dy;
      d_nxt.z = d_i.z - at;
    end else begin
      d_nxt.x = d_i.x + dx;
      d_nxt.y = d_i.y - dy;
      d_nxt.z = d_i.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_o = d_r;

endmodule

// ===== src/e2q_quat.sv =====
// Quaternion back end: sign fix of sine/cosine, two rounds of products,
// rounding and saturation to Q2.30. Uses e2q_pkg.
module e2q_quat (
  input  logic               clk,
  input  logic               en,
  input  e2q_pkg::cordic_t   p_i,
  input  e2q_pkg::cordic_t   y_i,
  input  e2q_pkg::cordic_t   r_i,
  output logic signed [31:0] quat_x_o,
  output logic signed [31:0] quat_y_o,
  output logic signed [31:0] quat_z_o,
  output logic signed [31:0] quat_w_o
);
  import e2q_pkg::*;

  localparam int PW = 2 * ANG_W;

  function automatic logic signed [ANG_W-1:0] rnd2(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] t;
    t = (p + PW'(64'sd536870912)) >>> 30;
    return t[ANG_W-1:0];
  endfunction

  function automatic logic signed [31:0] rnd_sat(input logic signed [PW:0] s);
    logic signed [PW:0] t;
    t = (s + (PW+1)'(64'sd536870912)) >>> 30;
    if (t > (PW+1)'(64'sd2147483647)) begin
      return 32'sh7FFFFFFF;
    end else if (t < -(PW+1)'(64'sd2147483648)) begin
      return 32'sh80000000;
    end
    return t[31:0];
  endfunction

  // Q0
  logic signed [ANG_W-1:0] sp_r, cp_r, sy_r, cy_r, sr_r, cr_r;
  // Q1
  logic signed [PW-1:0]    crsp_r1, srcp_r1, crcp_r1, srsp_r1;
  logic signed [ANG_W-1:0] sy_r1, cy_r1;
  // Q2
  logic signed [ANG_W-1:0] crsp_r2, srcp_r2, crcp_r2, srsp_r2;
  logic signed [ANG_W-1:0] sy_r2, cy_r2;
  // Q3
  logic signed [PW-1:0]    m0_r, m1_r, m2_r, m3_r, m4_r, m5_r, m6_r, m7_r;
  // Q4
  logic signed [31:0]      qx_r, qy_r, qz_r, qw_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sp_r <= p_i.flip ? -p_i.y : p_i.y;
      cp_r <= p_i.flip ? -p_i.x : p_i.x;
      sy_r <= y_i.flip ? -y_i.y : y_i.y;
      cy_r <= y_i.flip ? -y_i.x : y_i.x;
      sr_r <= r_i.flip ? -r_i.y : r_i.y;
      cr_r <= r_i.flip ? -r_i.x : r_i.x;

      crsp_r1 <= PW'(cr_r) * PW'(sp_r);
      srcp_r1 <= PW'(sr_r) * PW'(cp_r);
      crcp_r1 <= PW'(cr_r) * PW'(cp_r);
      srsp_r1 <= PW'(sr_r) * PW'(sp_r);
      sy_r1   <= sy_r;
      cy_r1   <= cy_r;

      crsp_r2 <= rnd2(crsp_r1);
      srcp_r2 <= rnd2(srcp_r1);
      crcp_r2 <= rnd2(crcp_r1);
      srsp_r2 <= rnd2(srsp_r1);
      sy_r2   <= sy_r1;
      cy_r2   <= cy_r1;

      m0_r <= PW'(crsp_r2) * PW'(sy_r2);
      m1_r <= PW'(srcp_r2) * PW'(cy_r2);
      m2_r <= PW'(crsp_r2) * PW'(cy_r2);
      m3_r <= PW'(srcp_r2) * PW'(sy_r2);
      m4_r <= PW'(crcp_r2) * PW'(sy_r2);
      m5_r <= PW'(srsp_r2) * PW'(cy_r2);
      m6_r <= PW'(crcp_r2) * PW'(cy_r2);
      m7_r <= PW'(srsp_r2) * PW'(sy_r2);

      qx_r <= rnd_sat((PW+1)'(m0_r) - (PW+1)'(m1_r));
      qy_r <= rnd_sat(-(PW+1)'(m2_r) - (PW+1)'(m3_r));
      qz_r <= rnd_sat((PW+1)'(m4_r) - (PW+1)'(m5_r));
      qw_r <= rnd_sat((PW+1)'(m6_r) + (PW+1)'(m7_r));
    end
  end

  assign quat_x_o = qx_r;
  assign quat_y_o = qy_r;
  assign quat_z_o = qz_r;
  assign quat_w_o = qw_r;

endmodule

// ===== bench/euler_to_quaternion_top_tb.sv =====
// Testbench for euler_to_quaternion_top. It drives Euler angle transactions and
// checks each quaternion against a predictor. Depends on e2q_pkg and the block RTL.
module euler_to_quaternion_top_tb;

  // One expected quaternion, held in the order the inputs were accepted
  typedef struct {
    logic signed [31:0] x, y, z, w;
  } quat_t;

  localparam longint DEG360_Q16 = 64'sd23592960;
  localparam int     STAGES     = e2q_pkg::CORDIC_STAGES_DEF;
  localparam int     LATENCY    = 15 + STAGES;
  localparam longint CYCLE_LIMIT = 400000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic signed [31:0] in_pitch_deg, in_yaw_deg, in_roll_deg;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] out_quat_x, out_quat_y, out_quat_z, out_quat_w;

  quat_t  quat_pending[$];
  int     mismatches = 0;
  int     quats_seen = 0;
  longint cycle_count = 0;
  int     send_idle_pct;   // chance in 100 that the sender idles a cycle
  int     recv_stall_pct;  // chance in 100 that the receiver stalls

  euler_to_quaternion_top #(.CORDIC_STAGES(STAGES)) u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_pitch_deg (in_pitch_deg),
    .in_yaw_deg   (in_yaw_deg),
    .in_roll_deg  (in_roll_deg),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_quat_x   (out_quat_x),
    .out_quat_y   (out_quat_y),
    .out_quat_z   (out_quat_z),
    .out_quat_w   (out_quat_w)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Arctangent of 2^-k in Q2.30
  function automatic longint atan_step(input int k);
    case (k)
      0:  return 64'h3243F6A8;
      1:  return 64'h1DAC6705;
      2:  return 64'h0FADBAFC;
      3:  return 64'h07F56EA6;
      4:  return 64'h03FEAB76;
      5:  return 64'h01FFD55B;
      6:  return 64'h00FFFAAA;
      7:  return 64'h007FFF55;
      8:  return 64'h003FFFEA;
      9:  return 64'h001FFFFD;
      10: return 64'h000FFFFF;
      11: return 64'h0007FFFF;
      12: return 64'h0003FFFF;
      13: return 64'h0001FFFF;
      14: return 64'h0000FFFF;
      15: return 64'h00007FFF;
      16: return 64'h00003FFF;
      17: return 64'h00001FFF;
      18: return 64'h00000FFF;
      19: return 64'h000007FF;
      20: return 64'h000003FF;
      21: return 64'h000001FF;
      22: return 64'h000000FF;
      23: return 64'h0000007F;
      24: return 64'h0000003F;
      25: return 64'h0000001F;
      26: return 64'h0000000F;
      27: return 64'h00000008;
      28: return 64'h00000004;
      29: return 64'h00000002;
      30: return 64'h00000001;
      default: return 64'sd0;
    endcase
  endfunction

  // Q4.60 back to Q2.30, round half up via floor shift
  function automatic longint round_q60(input longint v);
    return (v + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647)  return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Sine and cosine of half the angle, Q2.30
  task automatic half_angle_sincos(input logic signed [31:0] deg,
                                   output longint s, output longint c);
    longint red, num, mag, q, theta, x, y, z, dx, dy;
    bit     flip;
    red   = longint'(deg) % DEG360_Q16;
    num   = red * longint'(e2q_pkg::PI_Q30);
    mag   = (num < 0) ? -num : num;
    q     = (mag + DEG360_Q16 / 2) / DEG360_Q16;
    theta = (num < 0) ? -q : q;
    flip  = 1'b0;
    if (theta > longint'(e2q_pkg::HALF_PI_Q30)) begin
      theta -= longint'(e2q_pkg::PI_Q30);
      flip = 1'b1;
    end else if (theta < -longint'(e2q_pkg::HALF_PI_Q30)) begin
      theta += longint'(e2q_pkg::PI_Q30);
      flip = 1'b1;
    end
    x = longint'(e2q_pkg::CORDIC_GAIN_Q30);
    y = 0;
    z = theta;
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> (i & 31);
      dy = x >>> (i & 31);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_step(i & 31);
      end else begin
        x += dx; y -= dy; z += atan_step(i & 31);
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    s = y;
    c = x;
  endtask

  task automatic predict_quat(input logic signed [31:0] pitch, yaw, roll,
                              output quat_t q);
    longint sp, cp, sy, cy, sr, cr, crsp, srcp, crcp, srsp;
    half_angle_sincos(pitch, sp, cp);
    half_angle_sincos(yaw, sy, cy);
    half_angle_sincos(roll, sr, cr);
    crsp = round_q60(cr * sp);
    srcp = round_q60(sr * cp);
    crcp = round_q60(cr * cp);
    srsp = round_q60(sr * sp);
    q.x = clamp32(round_q60(crsp * sy - srcp * cy));
    q.y = clamp32(round_q60(-(crsp * cy) - srcp * sy));
    q.z = clamp32(round_q60(crcp * sy - srsp * cy));
    q.w = clamp32(round_q60(crcp * cy + srsp * sy));
  endtask

  task automatic report_mismatch(input string what, input logic signed [31:0] got, want);
    $display("[%0t] mismatch %s: got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // One transaction: optional idle cycles, then hold until accepted
  task automatic send_angles(input logic signed [31:0] pitch, yaw, roll);
    quat_t q;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_pitch_deg <= pitch;
    in_yaw_deg   <= yaw;
    in_roll_deg  <= roll;
    do @(posedge clk); while (in_stall);
    predict_quat(pitch, yaw, roll, q);
    quat_pending.push_back(q);
  endtask

  // Random angle biased toward quadrant and wrap boundaries
  function automatic logic signed [31:0] pick_angle();
    int k;
    k = $urandom_range(9);
    if (k < 4) return $urandom;
    if (k < 7) return $signed(($urandom_range(16) - 8) * 32'sd5898240)
                      + $signed($urandom_range(4)) - 32'sd2;
    return $signed($urandom_range(47185920)) - 32'sd23592960;
  endfunction

  task automatic drain_quats();
    in_valid <= 1'b0;
    while (quat_pending.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stalls, changed once per edge
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else        out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Result checker: each accepted quaternion against the oldest prediction
  always @(posedge clk) begin
    quat_t want;
    if (rst_n && out_valid && !out_stall) begin
      quats_seen++;
      if (quat_pending.size() == 0) begin
        report_mismatch("unexpected x", out_quat_x, 32'sd0);
      end else begin
        want = quat_pending.pop_front();
        if (out_quat_x !== want.x) report_mismatch("x", out_quat_x, want.x);
        if (out_quat_y !== want.y) report_mismatch("y", out_quat_y, want.y);
        if (out_quat_z !== want.z) report_mismatch("z", out_quat_z, want.z);
        if (out_quat_w !== want.w) report_mismatch("w", out_quat_w, want.w);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d outstanding", cycle_count,
               quat_pending.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Directed rows: pitch, yaw, roll. All checked by the predictor.
  localparam int N_DIRECTED = 18;
  logic signed [31:0] directed_rows [N_DIRECTED][3] = '{
    '{32'sd0,           32'sd0,           32'sd0},
    '{32'sh7FFFFFFF,    32'sh7FFFFFFF,    32'sh7FFFFFFF},
    '{32'sh80000000,    32'sh80000000,    32'sh80000000},
    '{32'sh7FFFFFFF,    32'sh80000000,    32'sd0},
    '{32'sd5898240,     32'sd0,           32'sd0},        // 90 deg pitch
    '{32'sd0,           32'sd11796480,    32'sd0},        // 180 deg yaw
    '{32'sd0,           32'sd0,           32'sd23592960}, // full turn wraps
    '{-32'sd23592960,   32'sd23592961,    -32'sd23592961},
    '{32'sd11796481,    -32'sd11796481,   32'sd11796479}, // fold edges
    '{-32'sd11796480,   32'sd17694720,    -32'sd17694720},
    '{32'sd23592959,    -32'sd23592959,   32'sd1},
    '{-32'sd1,          32'sd1,           -32'sd1},
    '{32'sd2949120,     32'sd2949120,     32'sd2949120},  // 45 deg each
    '{32'sh55555555,    32'shAAAAAAAA,    32'sh0F0F0F0F},
    '{32'shAAAAAAAA,    32'sh55555555,    32'shF0F0F0F0},
    '{32'sd47185920,    -32'sd70778880,   32'sd94371840}, // multiples of 360
    '{32'sd5898239,     -32'sd5898241,    32'sd5898241},
    '{32'sd17694721,    32'sd29491200,    -32'sd29491201}
  };

  initial begin
    int phase_idle[4]  = '{0, 69, 0, 15};
    int phase_stall[4] = '{0, 0, 69, 15};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_pitch_deg = '0;
    in_yaw_deg = '0;
    in_roll_deg = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++)
      send_angles(directed_rows[i][0], directed_rows[i][1], directed_rows[i][2]);
    // hold off until the pipe is empty
    drain_quats();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = phase_idle[p];
      recv_stall_pct = phase_stall[p];
      repeat (235) send_angles(pick_angle(), pick_angle(), pick_angle());
    end
    drain_quats();
    recv_stall_pct = 0;
    repeat (LATENCY * 2) @(posedge clk);

    $display("Covered %0d quaternions: directed extremes and fold edges, then random",
             quats_seen);
    $display("angles across sender idle and receiver stall mixes; %0d mismatches.",
             mismatches);
    if (mismatches == 0 && quat_pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
